// ===== hdl/fmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmp_pkg: shared types and constants of the Fibonacci matrix power unit
// Word widths, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package fmp_pkg;

  // Arithmetic word; every matrix entry is kept modulo 2^WORD_BITS
  localparam int WORD_BITS = 64;
  // Width of the index and result on the stream ports
  localparam int DATA_BITS = 64;
  // Operand half width of the shared multiplier
  localparam int HALF_BITS = (WORD_BITS + 1) / 2;
  localparam int PROD_BITS = 2 * HALF_BITS;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [HALF_BITS-1:0] half_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN0,
    ST_DRAIN1,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // Matrix entry being produced; the matrices are symmetric, c equals b
  typedef enum logic [1:0] {
    ENT_A,
    ENT_B,
    ENT_D
  } entry_t;

  // Partial product of a truncated word product: low*low, low*high, high*low
  typedef enum logic [1:0] {
    PP_LL,
    PP_LH,
    PP_HL
  } part_t;

  // Controller to datapath
  typedef struct packed {
    logic   load;      // capture a new index, set up the matrices
    logic   issue;     // a partial product enters the multiplier
    logic   sq;        // 1: base*base, 0: acc*base
    logic   term;      // which of the two products of an entry
    part_t  part;
    entry_t entry;
    logic   commit;    // copy the finished product into its matrix
    logic   shift_e;   // drop the exponent bit just handled
    logic   out_load;  // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic e_zero;
    logic e_bit0;
    logic e_upper_zero;
  } status_t;

endpackage

// ===== hdl/fmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmp_ctrl: sequencer of the Fibonacci matrix power unit
// Walks the exponent bits and issues the partial products of each matrix
// product to the datapath; owns the stream handshakes.
// ----------------------------------------------------------------------------
module fmp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  fmp_pkg::status_t status,
  output fmp_pkg::cmd_t   cmd
);
  import fmp_pkg::*;

  state_t state, state_next;
  logic   sq, sq_next;
  part_t  part;
  logic   term;
  entry_t entry;
  logic   last_issue;
  logic   out_free;

  assign last_issue = (part == PP_HL) && term && (entry == ENT_D);
  assign out_free   = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    sq_next    = sq;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.e_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_ISSUE;
          sq_next    = !status.e_bit0;
        end
      end
      ST_ISSUE: begin
        if (last_issue) state_next = ST_DRAIN0;
      end
      ST_DRAIN0: state_next = ST_DRAIN1;
      ST_DRAIN1: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (sq) begin
          state_next = ST_CHECK;
        end else if (status.e_upper_zero) begin
          // last exponent bit: squaring the base is not needed
          state_next = ST_DONE;
        end else begin
          state_next = ST_ISSUE;
          sq_next    = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && s_tvalid;
    cmd.issue    = (state == ST_ISSUE);
    cmd.sq       = sq;
    cmd.term     = term;
    cmd.part     = part;
    cmd.entry    = entry;
    cmd.commit   = (state == ST_COMMIT);
    cmd.shift_e  = (state == ST_COMMIT) && sq;
    cmd.out_load = (state == ST_DONE) && out_free;
    s_tready     = (state == ST_IDLE);
  end

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sq       <= 1'b0;
      part     <= PP_LL;
      term     <= 1'b0;
      entry    <= ENT_A;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      sq       <= sq_next;
      m_tvalid <= cmd.out_load || (m_tvalid && !m_tready);
      // partial product counters, cleared outside the issue phase
      if (state != ST_ISSUE) begin
        part  <= PP_LL;
        term  <= 1'b0;
        entry <= ENT_A;
      end else begin
        unique case (part)
          PP_LL: part <= PP_LH;
          PP_LH: part <= PP_HL;
          default: begin
            part <= PP_LL;
            term <= !term;
            if (term) begin
              unique case (entry)
                ENT_A:   entry <= ENT_B;
                ENT_B:   entry <= ENT_D;
                default: entry <= ENT_A;
              endcase
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/fmp_datapath.sv =====
// ----------------------------------------------------------------------------
// fmp_datapath: matrices, exponent and shared multiplier
// One half-word multiplier with a registered product, followed by an
// accumulate stage that builds each truncated entry of a 2x2 product.
// ----------------------------------------------------------------------------
module fmp_datapath (
  input  logic              clk,
  input  logic              rst,
  input  fmp_pkg::cmd_t     cmd,
  output fmp_pkg::status_t  status,
  input  fmp_pkg::data_t    s_tdata,
  output fmp_pkg::data_t    m_tdata
);
  import fmp_pkg::*;

  // Matrices kept as a, b, d (c equals b for powers of [[1,1],[1,0]])
  word_t acc_a, acc_b, acc_d;
  word_t base_a, base_b, base_d;
  word_t tmp_a, tmp_b, tmp_d;
  data_t expo;
  logic  n_zero;

  word_t x_a, x_b, x_d, x_sel, y_sel;
  half_t x_half, y_half;

  prod_t  prod;
  logic   p_valid, p_shift, p_first, p_last;
  entry_t p_entry;

  word_t sum_q, addend, sum_next;

  // Operand selection: left factor is acc or base, right factor is base
  always_comb begin
    x_a = cmd.sq ? base_a : acc_a;
    x_b = cmd.sq ? base_b : acc_b;
    x_d = cmd.sq ? base_d : acc_d;
    unique case (cmd.entry)
      ENT_A: begin
        x_sel = cmd.term ? x_b : x_a;
        y_sel = cmd.term ? base_b : base_a;
      end
      ENT_B: begin
        x_sel = cmd.term ? x_b : x_a;
        y_sel = cmd.term ? base_d : base_b;
      end
      ENT_D: begin
        x_sel = cmd.term ? x_d : x_b;
        y_sel = cmd.term ? base_d : base_b;
      end
      default: begin
        x_sel = x_a;
        y_sel = base_a;
      end
    endcase
    x_half = (cmd.part == PP_HL) ? HALF_BITS'(x_sel >> HALF_BITS) : x_sel[HALF_BITS-1:0];
    y_half = (cmd.part == PP_LH) ? HALF_BITS'(y_sel >> HALF_BITS) : y_sel[HALF_BITS-1:0];
  end

  // Multiplier stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
    end
    prod    <= PROD_BITS'(x_half) * PROD_BITS'(y_half);
    p_shift <= (cmd.part != PP_LL);
    p_first <= (cmd.part == PP_LL) && !cmd.term;
    p_last  <= (cmd.part == PP_HL) && cmd.term;
    p_entry <= cmd.entry;
  end

  // Accumulate stage: cross products land one half word up
  always_comb begin
    addend   = p_shift ? WORD_BITS'({prod, {HALF_BITS{1'b0}}}) : WORD_BITS'(prod);
    sum_next = (p_first ? '0 : sum_q) + addend;
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      sum_q <= sum_next;
      if (p_last) begin
        unique case (p_entry)
          ENT_A:   tmp_a <= sum_next;
          ENT_B:   tmp_b <= sum_next;
          default: tmp_d <= sum_next;
        endcase
      end
    end
  end

  // Matrices, exponent and result; index zero gets a zero exponent
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      expo   <= (s_tdata == '0) ? '0 : s_tdata - DATA_BITS'(1);
      n_zero <= (s_tdata == '0);
      acc_a  <= WORD_BITS'(1);
      acc_b  <= '0;
      acc_d  <= WORD_BITS'(1);
      base_a <= WORD_BITS'(1);
      base_b <= WORD_BITS'(1);
      base_d <= '0;
    end else begin
      if (cmd.commit) begin
        if (cmd.sq) begin
          base_a <= tmp_a;
          base_b <= tmp_b;
          base_d <= tmp_d;
        end else begin
          acc_a <= tmp_a;
          acc_b <= tmp_b;
          acc_d <= tmp_d;
        end
      end
      if (cmd.shift_e) expo <= expo >> 1;
    end
    if (cmd.out_load) m_tdata <= n_zero ? '0 : DATA_BITS'(acc_a);
  end

  // Exponent status
  always_comb begin
    status.e_zero       = (expo == '0);
    status.e_bit0       = expo[0];
    status.e_upper_zero = ((expo >> 1) == '0);
  end

endmodule

// ===== hdl/fibonacci_matrix_power_unit.sv =====
// ----------------------------------------------------------------------------
// fibonacci_matrix_power_unit: F(n) by 2x2 matrix exponentiation
// Takes an index n and returns the Fibonacci number F(n) modulo 2^64.
// ----------------------------------------------------------------------------
// Each index is worked on alone. The unit raises [[1,1],[1,0]] to n-1 by
// square-and-multiply, low exponent bit first, on one shared half-word
// multiplier: a matrix product issues 18 partial products, then passes
// the drain states ST_DRAIN0 and ST_DRAIN1 and a commit. An exponent bit
// gets a test, a multiply of the accumulator by the base when the bit is
// set, then the squaring of the base (the top bit skips the squaring).
// An item holds the unit until its result is loaded, which waits while
// the previous result still waits on m_tready.
// Results wrap modulo 2^64 above n = 93; there is no overflow flag.
// A new index is taken while the previous result still waits on m_tready.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  fmp_pkg::data_t  s_tdata,   // [63:0] index_n
  output logic            m_tvalid,
  input  logic            m_tready,
  output fmp_pkg::data_t  m_tdata    // [63:0] fib_value
);
  import fmp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  fmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic
  fmp_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule
